// ----- rtl/page_table_map_insert_assert.svh -----
// Assertion macros shared by the page table map engine
`ifndef PAGE_TABLE_MAP_INSERT_ASSERT_SVH
`define PAGE_TABLE_MAP_INSERT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PTMI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PTMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ptmi_pkg.sv -----
// Shared constants, codes and controller/datapath interface types
package ptmi_pkg;

  // Table geometry
  localparam int TABLE_PAGES = 64;
  localparam int LEVELS      = 4;
  localparam int IDX_W       = 9;
  localparam int ENTRIES     = 512;
  localparam int PAGE_W      = $clog2(TABLE_PAGES);
  localparam int ADDR_W      = PAGE_W + IDX_W;
  localparam int DEPTH       = TABLE_PAGES * ENTRIES;
  localparam int NFP_W       = $clog2(TABLE_PAGES + 1);
  localparam int LVL_W       = $clog2(LEVELS);
  localparam int VA_W        = IDX_W * LEVELS;

  // Field widths
  localparam int PHYS_W      = 52;
  localparam int VIRT_W      = 36;
  localparam int FLAGS_W     = 12;
  localparam int STATUS_W    = 2;
  localparam int NEWT_W      = 2;
  localparam int ENTRY_W     = 64;
  localparam int FREE_W      = 7;
  localparam int FREE_MAX    = (1 << FREE_W) - 1;
  localparam int ROOT_W      = 6;
  localparam int FRAME_W     = 36;
  localparam int FRAME_LSB   = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 36;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 80;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_MAPPED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_PAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic                clr_wr;
    logic                start;
    logic                rd;
    logic                follow;
    logic                alloc;
    logic                leaf_wr;
    logic                set_err;
    logic [STATUS_W-1:0] err_code;
    logic                load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic root_bad;
    logic present;
    logic entry_out;
    logic pool_full;
    logic alloc_wrap;
    logic next_last;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/ptmi_ctrl.sv -----
// Walk sequencer: clearing pass, per-level read/evaluate, leaf write, result load
module ptmi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ptmi_pkg::sts_t sts,
  output ptmi_pkg::cmd_t cmd
);
  import ptmi_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_LEAF  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Hold state, reset into the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.err_code = ST_MAPPED;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = sts.root_bad ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.present) begin
          if (sts.entry_out) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_OUTSIDE;
            state_nxt    = S_DONE;
          end else begin
            cmd.follow = 1'b1;
            state_nxt  = sts.next_last ? S_LEAF : S_READ;
          end
        end else if (sts.pool_full) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_EXHAUSTED;
          state_nxt    = S_DONE;
        end else begin
          cmd.alloc = 1'b1;
          if (sts.alloc_wrap) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_OUTSIDE;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = sts.next_last ? S_LEAF : S_READ;
          end
        end
      end
      S_LEAF: begin
        cmd.leaf_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/ptmi_dpath.sv -----
// Datapath: table store, allocator, walk registers, config and output registers
module ptmi_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ptmi_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ptmi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptmi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ptmi_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  ptmi_pkg::cmd_t                   cmd,
  output ptmi_pkg::sts_t                   sts
);
  import ptmi_pkg::*;

  localparam int OUT_USED_W = STATUS_W + NEWT_W + ENTRY_W + FREE_W;
  localparam int HI_ZERO_W  = ENTRY_W - FRAME_W - FRAME_LSB;

  // Entry is allocated-page-owned when its page was handed out by the allocator
  function automatic logic page_alloc(input logic [PAGE_W-1:0] p,
                                      input logic [NFP_W-1:0]  n);
    return (p != '0) && (NFP_W'(p) < n);
  endfunction

  // Configuration
  logic [ROOT_W-1:0]  root_page_r;
  logic [FRAME_W-1:0] pool_base_r;

  // Walk and allocator state
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [NFP_W-1:0]    nf_r;
  logic [PHYS_W-1:0]   phys_r;
  logic [FLAGS_W-1:0]  flags_r;
  logic [VA_W-1:0]     vidx_r;
  logic [PAGE_W-1:0]   page_r;
  logic [ADDR_W-1:0]   slot_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [STATUS_W-1:0] status_r;
  logic [NEWT_W-1:0]   ncnt_r;
  logic [ENTRY_W-1:0]  leaf_r;

  // Table store: entry plus ownership tag
  logic [ENTRY_W:0]    mem [0:DEPTH-1];
  logic [ENTRY_W:0]    rdata_r;

  // Output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] o_status_r;
  logic [NEWT_W-1:0]   o_newt_r;
  logic [ENTRY_W-1:0]  o_leaf_r;
  logic [FREE_W-1:0]   o_free_r;

  // Combinational terms
  logic [PHYS_W-1:0]     in_phys;
  logic [VIRT_W-1:0]     in_virt;
  logic [FLAGS_W-1:0]    in_flags;
  logic [VA_W+VIRT_W-1:0] virt_ext;
  logic [31:0]           root_ext;
  logic [IDX_W-1:0]      cur_idx;
  logic [ADDR_W-1:0]     raddr;
  logic [PAGE_W-1:0]     slot_page;
  logic                  tag_ok;
  logic [FRAME_W-1:0]    rd_frame;
  logic [FRAME_W-1:0]    rd_diff;
  logic                  in_pool;
  logic [FRAME_W:0]      alloc_sum;
  logic [ENTRY_W-1:0]    alloc_entry;
  logic [ENTRY_W-1:0]    leaf_entry;
  logic [NFP_W-1:0]      nf_inc;
  logic [NFP_W-1:0]      free_raw;
  logic [NFP_W+FREE_W-1:0] free_ext;
  logic [FREE_W-1:0]     free_sat;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [ENTRY_W:0]      wdata;

  // Unpack the input word
  assign in_phys  = in_tdata[PHYS_W-1:0];
  assign in_virt  = in_tdata[PHYS_W +: VIRT_W];
  assign in_flags = in_tdata[PHYS_W+VIRT_W +: FLAGS_W];
  assign virt_ext = {{VA_W{1'b0}}, in_virt};
  assign root_ext = 32'(root_page_r);

  // Current level index and read address
  assign cur_idx   = vidx_r[VA_W-1 -: IDX_W];
  assign raddr     = {page_r, cur_idx};
  assign slot_page = slot_r[ADDR_W-1 -: PAGE_W];

  // Decode the entry just read
  assign tag_ok   = (rdata_r[ENTRY_W] == page_alloc(slot_page, nf_r));
  assign rd_frame = rdata_r[FRAME_LSB +: FRAME_W];
  assign rd_diff  = rd_frame - pool_base_r;
  assign in_pool  = (rd_frame >= pool_base_r) && (rd_diff < FRAME_W'(TABLE_PAGES));

  // New table entry and leaf entry
  assign alloc_sum   = {1'b0, pool_base_r} + (FRAME_W+1)'(nf_r);
  assign alloc_entry = {{HI_ZERO_W{1'b0}}, alloc_sum[FRAME_W-1:0], {FRAME_LSB{1'b0}}}
                     | ENTRY_W'(flags_r) | ENTRY_W'(1);
  assign leaf_entry  = {phys_r, flags_r};
  assign nf_inc      = nf_r + NFP_W'(1);

  // Free page count, saturated to the field
  assign free_raw = NFP_W'(TABLE_PAGES) - nf_r;
  assign free_ext = (NFP_W+FREE_W)'(free_raw);
  assign free_sat = (free_ext > (NFP_W+FREE_W)'(FREE_MAX)) ? FREE_W'(FREE_MAX)
                                                            : free_ext[FREE_W-1:0];

  // Status to the controller
  assign sts.clr_last   = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign sts.root_bad   = (root_ext >= 32'(TABLE_PAGES));
  assign sts.present    = tag_ok & rdata_r[0];
  assign sts.entry_out  = !in_pool;
  assign sts.pool_full  = (nf_r >= NFP_W'(TABLE_PAGES));
  assign sts.alloc_wrap = alloc_sum[FRAME_W];
  assign sts.next_last  = (lvl_r == LVL_W'(LEVELS - 2));
  assign sts.out_busy   = out_valid_r & ~out_tready;

  // Store write port select
  always_comb begin
    we    = 1'b0;
    waddr = slot_r;
    wdata = '0;
    if (cmd.clr_wr) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
    end else if (cmd.alloc) begin
      we    = 1'b1;
      waddr = slot_r;
      wdata = {page_alloc(slot_page, nf_inc), alloc_entry};
    end else if (cmd.leaf_wr) begin
      we    = 1'b1;
      waddr = raddr;
      wdata = {page_alloc(page_r, nf_r), leaf_entry};
    end
  end

  // Table store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[raddr];
    end
  end

  // Configuration writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_page_r <= '0;
      pool_base_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROOT_PAGE: root_page_r <= cfg_data[ROOT_W-1:0];
        REG_POOL_BASE: pool_base_r <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Control counters: clearing pass, allocator, level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      nf_r      <= NFP_W'(1);
      lvl_r     <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd.alloc) begin
        nf_r <= nf_inc;
      end
      if (cmd.start) begin
        lvl_r <= '0;
      end else if (cmd.follow || cmd.alloc) begin
        lvl_r <= lvl_r + LVL_W'(1);
      end
    end
  end

  // Request and walk registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      phys_r   <= in_phys;
      flags_r  <= in_flags;
      vidx_r   <= virt_ext[VA_W-1:0];
      page_r   <= root_ext[PAGE_W-1:0];
      status_r <= sts.root_bad ? ST_OUTSIDE : ST_MAPPED;
      ncnt_r   <= '0;
      leaf_r   <= '0;
    end else begin
      if (cmd.rd) begin
        slot_r <= raddr;
      end
      if (cmd.follow) begin
        page_r <= rd_diff[PAGE_W-1:0];
        vidx_r <= {vidx_r[VA_W-IDX_W-1:0], {IDX_W{1'b0}}};
      end
      if (cmd.alloc) begin
        page_r <= nf_r[PAGE_W-1:0];
        vidx_r <= {vidx_r[VA_W-IDX_W-1:0], {IDX_W{1'b0}}};
        ncnt_r <= ncnt_r + NEWT_W'(1);
      end
      if (cmd.set_err) begin
        status_r <= cmd.err_code;
      end
      if (cmd.leaf_wr) begin
        leaf_r <= leaf_entry;
      end
    end
  end

  // Output word valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_status_r <= status_r;
      o_newt_r   <= ncnt_r;
      o_leaf_r   <= (status_r == ST_MAPPED) ? leaf_r : '0;
      o_free_r   <= free_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                       o_free_r, o_leaf_r, o_newt_r, o_status_r};

endmodule

// ----- rtl/page_table_map_insert.sv -----
// Top level of the four-level page table map engine
//
// Input channel in_*: one map request per word (physical frame, virtual page,
// flags). Result channel out_*: one word per request with status, number of
// tables allocated, the leaf entry written and the free table pages left.
// Configuration channel cfg_*: index 0 root page, index 1 pool base frame;
// always ready, write only while no request is in flight.
// After reset the table store (TABLE_PAGES * 512 = 32768 entries) is swept to
// zero, one entry per cycle; in_tready stays low until the sweep is done.
// A request walks the table one level at a time through the store: the
// accept, a read and an evaluate step per upper level, the leaf write and
// the result load; an error ends the walk early. The result is on out_tdata
// the cycle after the load, and the next request is accepted in that cycle.
// A stalled receiver holds the result in the output register; the engine
// takes one more request and finishes it, then waits to load.
module page_table_map_insert (
  input  logic                             clk,
  input  logic                             rst_n,
  // phys_frame[51:0], virt_page[87:52], flags[99:88], zero pad[103:100]
  input  logic [ptmi_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // status[1:0], new_tables[3:2], leaf_entry[67:4], free_pages[74:68], pad
  output logic [ptmi_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ptmi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptmi_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ptmi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptmi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptmi_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

`include "page_table_map_insert_assert.svh"

  // Allocate only when the pool has room
  `PTMI_ASSERT_SAME(a_alloc_room, cmd.alloc, !sts.pool_full, "allocation from an exhausted pool")
  // One request at a time: busy right after an accept
  `PTMI_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accept while busy")
  // Never load a result over one that is still waiting
  `PTMI_ASSERT_SAME(a_no_overwrite, cmd.load_out, !(out_tvalid && !out_tready), "result overwritten")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the four-level page table map engine
module testbench;
  import ptmi_pkg::*;

  // Result word layout, lowest field last
  typedef struct packed {
    logic [FREE_W-1:0]   free_pages;
    logic [ENTRY_W-1:0]  leaf_entry;
    logic [NEWT_W-1:0]   new_tables;
    logic [STATUS_W-1:0] status;
  } map_result_t;

  localparam int RESULT_W = $bits(map_result_t);
  localparam int IN_PAD_W = IN_TDATA_W - PHYS_W - VIRT_W - FLAGS_W;

  // Mirror of the table store and allocator; predicts one result per request
  class page_map_tracker;
    bit [ENTRY_W-1:0] table_mem [DEPTH];
    int               next_page;
    bit [ROOT_W-1:0]  root_page;
    bit [FRAME_W-1:0] pool_base;
    map_result_t      pending_results [$];
    int               errors;

    function new();
      next_page = 1;
      root_page = '0;
      pool_base = '0;
      errors    = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      if (idx == REG_ROOT_PAGE) begin
        root_page = val[ROOT_W-1:0];
      end else begin
        pool_base = val[FRAME_W-1:0];
      end
    endfunction

    // Walk the mirrored tables, allocate missing levels, write the leaf
    function map_result_t predict_map(bit [PHYS_W-1:0] phys, bit [VIRT_W-1:0] virt,
                                      bit [FLAGS_W-1:0] flags);
      map_result_t      r;
      int               page;
      int               level;
      int               slot;
      int               k;
      int               free_cnt;
      bit [IDX_W-1:0]   idx;
      bit [FRAME_W-1:0] frame;

      r = '0;
      page = root_page;
      if (root_page >= TABLE_PAGES) r.status = ST_OUTSIDE;
      for (level = 0; level < LEVELS && r.status == ST_MAPPED; level++) begin
        idx  = IDX_W'(virt >> (IDX_W * (LEVELS - 1 - level)));
        slot = page * ENTRIES + idx;
        if (level == LEVELS - 1) begin
          r.leaf_entry = {phys, flags};
          table_mem[slot] = {phys, flags};
          break;
        end
        // Allocate a zeroed table behind a missing entry
        if (!table_mem[slot][0]) begin
          if (next_page >= TABLE_PAGES) begin
            r.status = ST_EXHAUSTED;
            break;
          end
          for (k = 0; k < ENTRIES; k++) table_mem[next_page * ENTRIES + k] = '0;
          frame = FRAME_W'(pool_base + next_page);
          next_page++;
          r.new_tables = r.new_tables + 1'b1;
          table_mem[slot] = {{(ENTRY_W - FRAME_W - FRAME_LSB){1'b0}}, frame,
                             flags | 12'h001};
        end
        // Follow the entry; it must land inside the pool
        frame = table_mem[slot][FRAME_LSB +: FRAME_W];
        if (frame < pool_base || (frame - pool_base) >= FRAME_W'(TABLE_PAGES)) begin
          r.status = ST_OUTSIDE;
          break;
        end
        page = int'(frame - pool_base);
      end
      if (r.status != ST_MAPPED) r.leaf_entry = '0;
      free_cnt = (next_page < TABLE_PAGES) ? TABLE_PAGES - next_page : 0;
      if (free_cnt > FREE_MAX) free_cnt = FREE_MAX;
      r.free_pages = FREE_W'(free_cnt);
      return r;
    endfunction

    function map_result_t note_request(bit [PHYS_W-1:0] phys, bit [VIRT_W-1:0] virt,
                                       bit [FLAGS_W-1:0] flags);
      map_result_t r;
      r = predict_map(phys, virt, flags);
      pending_results.push_back(r);
      return r;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one result word against the oldest prediction
    task check_result(map_result_t got);
      map_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.new_tables !== want.new_tables)
        report($sformatf("new_tables got %0d want %0d", got.new_tables, want.new_tables));
      if (got.leaf_entry !== want.leaf_entry)
        report($sformatf("leaf_entry got %h want %h", got.leaf_entry, want.leaf_entry));
      if (got.free_pages !== want.free_pages)
        report($sformatf("free_pages got %0d want %0d", got.free_pages, want.free_pages));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  page_map_tracker tracker = new();
  bit [VIRT_W-1:0] mapped_virts [$];
  int              items_sent = 0;
  wire             quiet = (items_sent >= 700) && (items_sent < 950);

  page_table_map_insert dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side now and then, except in the quiet stretch
  always @(posedge clk) begin
    out_tready <= rst_n && (quiet || $urandom_range(99) >= 8);
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(map_result_t'(out_tdata[RESULT_W-1:0]));
  end

  // Send one request word; returns at the accepting edge with valid still high
  task automatic send_map(input bit [PHYS_W-1:0] phys, input bit [VIRT_W-1:0] virt,
                          input bit [FLAGS_W-1:0] flags);
    map_result_t r;
    while (!quiet && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {{IN_PAD_W{1'b0}}, flags, virt, phys};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = tracker.note_request(phys, virt, flags);
    items_sent++;
    // Remember pages that walked through, so later requests reuse their tables
    if (r.status == ST_MAPPED) begin
      if (mapped_virts.size() < 24) mapped_virts.push_back(virt);
      else mapped_virts[$urandom_range(23)] = virt;
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_config(input bit [ROOT_W-1:0] root, input bit [FRAME_W-1:0] base);
    cfg_index <= REG_ROOT_PAGE;
    cfg_data  <= CFG_DATA_W'(root);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(REG_ROOT_PAGE, CFG_DATA_W'(root));
    cfg_index <= REG_POOL_BASE;
    cfg_data  <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(REG_POOL_BASE, base);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [PHYS_W-1:0] pick_phys();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return PHYS_W'($urandom_range(127));
    if (sel < 25) return sel[0] ? '1 : '0;
    return PHYS_W'({$urandom, $urandom});
  endfunction

  function automatic bit [FLAGS_W-1:0] pick_flags();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return 12'h000;
    if (sel < 10) return 12'h001;
    if (sel < 15) return 12'h003;
    if (sel < 20) return 12'hFFF;
    return FLAGS_W'($urandom);
  endfunction

  // Mostly reuse known upper levels with a fresh leaf index; some new paths
  function automatic bit [VIRT_W-1:0] pick_virt();
    int              sel;
    bit [VIRT_W-1:0] v;
    sel = $urandom_range(99);
    if (mapped_virts.size() == 0 || sel < 8) begin
      v = VIRT_W'({$urandom, $urandom});
    end else if (sel < 12) begin
      v = sel[0] ? '1 : '0;
    end else begin
      v = mapped_virts[$urandom_range(mapped_virts.size() - 1)];
      if (sel < 20) v[2*IDX_W-1:IDX_W] = IDX_W'($urandom);
      v[IDX_W-1:0] = IDX_W'($urandom);
    end
    return v;
  endfunction

  task automatic run_phase(input bit [ROOT_W-1:0] root, input bit [FRAME_W-1:0] base,
                           input int count);
    write_config(root, base);
    repeat (count) send_map(pick_phys(), pick_virt(), pick_flags());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Fresh paths, shared paths, field extremes and alternating bit patterns
    write_config(6'd0, 36'h0);
    send_map(52'h0, 36'h0, 12'h003);
    send_map('1, '1, 12'hFFF);
    send_map(52'h123456789ABCD, 36'h0000001FF, 12'h000);
    send_map(52'h5, 36'h000000200, 12'h002);
    send_map(52'h7, 36'h000040000, 12'h001);
    send_map(52'hAAAAAAAAAAAAA, 36'h555555555, 12'hAAA);
    send_map(52'h5555555555555, 36'hAAAAAAAAA, 12'h555);
    drain();

    // Pool at the top of the frame space: old entries fall below it, new frames wrap
    write_config(6'd0, '1);
    send_map(52'h1, 36'h0, 12'h003);
    send_map(52'h2, 36'h080000000, 12'h003);
    drain();

    // High pool base: a full path allocated inside it
    write_config(6'd0, 36'h800000000);
    send_map(52'h42, 36'h800000000, 12'h007);
    drain();

    // Root at the last pool page, which the allocator may later hand out
    write_config(6'd63, 36'h0);
    send_map(52'h3, 36'h0, 12'h003);
    send_map(52'h9, 36'h000000001, 12'h001);
    drain();

    // Entry that points beyond the end of the pool
    write_config(6'd0, 36'h0);
    send_map(52'h11, 36'h800000000, 12'h003);
    drain();

    // Random traffic across several settings
    run_phase(6'd0, 36'h0, 500);
    run_phase(6'd63, 36'h0, 120);
    run_phase(ROOT_W'($urandom_range(62, 1)), 36'h0, 150);
    run_phase(6'd0, FRAME_W'({$urandom, $urandom}), 100);
    run_phase(6'd0, '1, 80);
    run_phase(ROOT_W'($urandom_range(62, 1)), 36'h0, 150);
    run_phase(6'd0, 36'h0, 550);

    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5000000;
    $display("testbench failed");
    $finish;
  end
endmodule

// ----- page_table_map_insert.f -----
+incdir+rtl
rtl/ptmi_pkg.sv
rtl/ptmi_ctrl.sv
rtl/ptmi_dpath.sv
rtl/page_table_map_insert.sv
dv/testbench.sv
